FILE: sv/dns_question_name_length_check_core_macros.svh
// Assertion macros for the DNS question name length check core.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef DNS_QUESTION_NAME_LENGTH_CHECK_CORE_MACROS_SVH
`define DNS_QUESTION_NAME_LENGTH_CHECK_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define DQNLC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dqnlc check failed");

// Next-cycle implication, disabled while reset is low
`define DQNLC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dqnlc check failed");

`endif

FILE: sv/dqnlc_pkg.sv
// Shared types and constants for the DNS question name length check core.
// No dependencies; imported by every module of the block.
package dqnlc_pkg;

    // DNS header layout
    localparam int unsigned HEADER_BYTES_DEF = 12;
    localparam int unsigned QDCOUNT_HI_POS   = 4;
    localparam int unsigned QDCOUNT_LO_POS   = 5;
    localparam int unsigned TAIL_BYTES       = 4;

    // Stream and register widths
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned COUNT_W     = 16;
    localparam int unsigned OUT_TDATA_W = 32;
    localparam int unsigned APB_DATA_W  = 32;
    localparam int unsigned APB_ADDR_W  = 3;

    // Register word indexes
    localparam logic [0:0] REG_LENGTH_THRESHOLD = 1'b0;

    // One result item
    typedef struct packed {
        logic               match;
        logic               malformed;
        logic [COUNT_W-1:0] question_count;
        logic [BYTE_W-1:0]  first_name_length;
    } t_result;

endpackage

FILE: sv/dqnlc_in_stage.sv
// Input register of the DNS question name length check core.
// Depends on dqnlc_pkg; holds one accepted item until the parser takes it.
module dqnlc_in_stage (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_tvalid,
    output logic                       o_s_tready,
    input  logic [dqnlc_pkg::BYTE_W-1:0] i_s_tdata,
    input  logic                       i_s_tlast,
    input  logic                       i_s_tuser,
    input  logic                       i_out_busy,
    output logic                       o_valid,
    output logic [dqnlc_pkg::BYTE_W-1:0] o_byte,
    output logic                       o_last,
    output logic                       o_udp,
    output logic                       o_advance
);
    import dqnlc_pkg::*;

    logic              r_valid;
    logic [BYTE_W-1:0] r_byte;
    logic              r_last;
    logic              r_udp;

    // Advance unless the held item carries a result and the output is full
    assign o_advance  = r_valid && !(r_last && i_out_busy);
    assign o_s_tready = !r_valid || o_advance;

    // Hold valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_valid <= i_s_tvalid;
        end
    end

    // Capture payload
    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_byte <= i_s_tdata;
            r_last <= i_s_tlast;
            r_udp  <= i_s_tuser;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;
    assign o_last  = r_last;
    assign o_udp   = r_udp;
endmodule

FILE: sv/dqnlc_parser.sv
// Parse state and per-byte update of the DNS question name length check core.
// Depends on dqnlc_pkg; walks header, labels and type/class one byte a cycle while i_advance is high.
module dqnlc_parser #(
    parameter int unsigned HEADER_BYTES = dqnlc_pkg::HEADER_BYTES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_advance,
    input  logic [dqnlc_pkg::BYTE_W-1:0] i_byte,
    input  logic                         i_last,
    input  logic                         i_udp,
    input  logic [dqnlc_pkg::BYTE_W-1:0] i_threshold,
    output dqnlc_pkg::t_result           o_result
);
    import dqnlc_pkg::*;

    localparam int unsigned POS_W = $clog2(HEADER_BYTES);
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(HEADER_BYTES - 1);
    localparam logic [POS_W-1:0] QC_HI    = POS_W'(QDCOUNT_HI_POS);
    localparam logic [POS_W-1:0] QC_LO    = POS_W'(QDCOUNT_LO_POS);
    localparam int unsigned TAIL_W = $clog2(TAIL_BYTES + 1);

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_LABEL_LEN,
        PH_LABEL_BODY,
        PH_TAIL,
        PH_DONE
    } t_phase;

    t_phase             r_phase,      n_phase;
    logic [POS_W-1:0]   r_pos,        n_pos;
    logic [COUNT_W-1:0] r_hdr_count,  n_hdr_count;
    logic [COUNT_W-1:0] r_q_left,     n_q_left;
    logic [BYTE_W-1:0]  r_label_left, n_label_left;
    logic [BYTE_W-1:0]  r_name_len,   n_name_len;
    logic [BYTE_W-1:0]  r_first_len,  n_first_len;
    logic               r_first_done, n_first_done;
    logic [TAIL_W-1:0]  r_tail_left,  n_tail_left;

    logic [BYTE_W+1:0]  len_sum;
    logic               header_done;
    logic               bad;

    // Saturating name length: current + label length + dot
    assign len_sum = {2'b00, r_name_len} + {2'b00, i_byte} + (BYTE_W+2)'(1);

    // Next state for one byte
    always_comb begin
        n_phase      = r_phase;
        n_pos        = r_pos;
        n_hdr_count  = r_hdr_count;
        n_q_left     = r_q_left;
        n_label_left = r_label_left;
        n_name_len   = r_name_len;
        n_first_len  = r_first_len;
        n_first_done = r_first_done;
        n_tail_left  = r_tail_left;
        case (r_phase)
            PH_HEADER: begin
                if (r_pos == QC_HI) begin
                    n_hdr_count = {i_byte, r_hdr_count[BYTE_W-1:0]};
                end else if (r_pos == QC_LO) begin
                    n_hdr_count = {r_hdr_count[COUNT_W-1:BYTE_W], i_byte};
                end
                if (r_pos >= LAST_POS) begin
                    n_q_left = r_hdr_count;
                    if (r_hdr_count == '0) begin
                        n_phase = PH_DONE;
                    end else begin
                        n_phase    = PH_LABEL_LEN;
                        n_name_len = '0;
                    end
                end else begin
                    n_pos = r_pos + POS_W'(1);
                end
            end
            PH_LABEL_LEN: begin
                if (i_byte != '0) begin
                    n_name_len   = len_sum[BYTE_W+1:BYTE_W] != 2'b00 ? '1
                                                                  : len_sum[BYTE_W-1:0];
                    n_label_left = i_byte;
                    n_phase      = PH_LABEL_BODY;
                end else begin
                    n_tail_left = TAIL_W'(TAIL_BYTES);
                    n_phase     = PH_TAIL;
                end
            end
            PH_LABEL_BODY: begin
                n_label_left = r_label_left - BYTE_W'(1);
                if (r_label_left == BYTE_W'(1)) begin
                    n_phase = PH_LABEL_LEN;
                end
            end
            PH_TAIL: begin
                n_tail_left = r_tail_left - TAIL_W'(1);
                if (r_tail_left == TAIL_W'(1)) begin
                    if (!r_first_done) begin
                        n_first_len  = r_name_len;
                        n_first_done = 1'b1;
                    end
                    n_q_left = r_q_left - COUNT_W'(1);
                    if (r_q_left == COUNT_W'(1)) begin
                        n_phase = PH_DONE;
                    end else begin
                        n_phase    = PH_LABEL_LEN;
                        n_name_len = '0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Verdict on the end byte, taken from the updated state
    assign header_done = n_phase != PH_HEADER;
    assign bad = (n_phase == PH_LABEL_LEN) || (n_phase == PH_LABEL_BODY) ||
                 (n_phase == PH_TAIL);

    always_comb begin
        o_result = '0;
        if (i_udp && header_done) begin
            o_result.match             = n_first_done && (n_first_len > i_threshold);
            o_result.malformed         = bad;
            o_result.question_count    = n_hdr_count;
            o_result.first_name_length = n_first_done ? n_first_len : '0;
        end
    end

    // Advance state; the end byte returns everything to the header phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_advance && i_last)) begin
            r_phase      <= PH_HEADER;
            r_pos        <= '0;
            r_hdr_count  <= '0;
            r_q_left     <= '0;
            r_label_left <= '0;
            r_name_len   <= '0;
            r_first_len  <= '0;
            r_first_done <= 1'b0;
            r_tail_left  <= '0;
        end else if (i_advance) begin
            r_phase      <= n_phase;
            r_pos        <= n_pos;
            r_hdr_count  <= n_hdr_count;
            r_q_left     <= n_q_left;
            r_label_left <= n_label_left;
            r_name_len   <= n_name_len;
            r_first_len  <= n_first_len;
            r_first_done <= n_first_done;
            r_tail_left  <= n_tail_left;
        end
    end
endmodule

FILE: sv/dqnlc_out_stage.sv
// Result register of the DNS question name length check core.
// Depends on dqnlc_pkg; holds one result item until the receiver takes it.
module dqnlc_out_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  dqnlc_pkg::t_result i_result,
    input  logic               i_m_tready,
    output logic               o_m_tvalid,
    output logic               o_busy,
    output dqnlc_pkg::t_result o_result
);
    import dqnlc_pkg::*;

    logic    r_valid;
    t_result r_result;

    // Load a new result or drop the one taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_busy     = r_valid && !i_m_tready;
    assign o_m_tvalid = r_valid;
    assign o_result   = r_result;
endmodule

FILE: sv/dns_question_name_length_check_core.sv
// Top level of the DNS question name length check core.
// Depends on dqnlc_pkg, dqnlc_in_stage, dqnlc_parser, dqnlc_out_stage and the macros header.
//
// Usage: the slave stream carries the UDP payload, one byte per item, with
// tlast on the last byte and tuser set when the packet is UDP with data
// (sampled on the last byte). The parser reads the 12-byte DNS header and
// walks every question's labels and type/class bytes. Exactly one result
// item leaves the master stream per packet, for its last byte: match,
// malformed, question count and saturated first name length.
// Throughput: one byte per cycle unless an end byte waits on a full output register, set
// by the combinational parse step between the input register and the result register.
// The output register loads a result as its last byte leaves the input register.
// When the receiver stalls, the result waits in the output register; the
// input keeps taking bytes of the next packet until its last byte reaches
// the parser, which then holds until the output register frees.
// Reset (synchronous, active low) clears the parse state, both stage
// valids and the length threshold. The APB register length_threshold
// (address 0) is to be written only while the block is idle; the block itself does not enforce it.
`include "dns_question_name_length_check_core_macros.svh"

module dns_question_name_length_check_core #(
    parameter int unsigned HEADER_BYTES = dqnlc_pkg::HEADER_BYTES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Payload stream
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [dqnlc_pkg::BYTE_W-1:0]      i_s_tdata,  // [7:0] payload_byte
    input  logic                              i_s_tlast,  // end_of_packet
    input  logic                              i_s_tuser,  // udp_with_data
    // Result stream
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // [0] match, [1] malformed, [17:2] question_count,
    // [25:18] first_name_length, [31:26] zero
    output logic [dqnlc_pkg::OUT_TDATA_W-1:0] o_m_tdata,
    // Configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [dqnlc_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [dqnlc_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [dqnlc_pkg::APB_DATA_W-1:0]  prdata,
    output logic                              pready
);
    import dqnlc_pkg::*;

    localparam int unsigned RES_W = $bits(t_result);

    logic              thr_wr;
    logic [BYTE_W-1:0] r_length_threshold;
    logic              reg_hit;

    logic              in_valid;
    logic [BYTE_W-1:0] in_byte;
    logic              in_last;
    logic              in_udp;
    logic              advance;
    logic              out_busy;
    t_result           parse_result;
    t_result           out_result;

    // Register access
    assign pready  = 1'b1;
    assign reg_hit = paddr[APB_ADDR_W-1:2] == REG_LENGTH_THRESHOLD;
    assign thr_wr  = psel && penable && pwrite && reg_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_length_threshold <= '0;
        end else if (thr_wr) begin
            r_length_threshold <= pwdata[BYTE_W-1:0];
        end
    end

    assign prdata = reg_hit ? {{(APB_DATA_W-BYTE_W){1'b0}}, r_length_threshold} : '0;

    dqnlc_in_stage u_in_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .i_s_tuser  (i_s_tuser),
        .i_out_busy (out_busy),
        .o_valid    (in_valid),
        .o_byte     (in_byte),
        .o_last     (in_last),
        .o_udp      (in_udp),
        .o_advance  (advance)
    );

    dqnlc_parser #(
        .HEADER_BYTES (HEADER_BYTES)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (advance),
        .i_byte      (in_byte),
        .i_last      (in_last),
        .i_udp       (in_udp),
        .i_threshold (r_length_threshold),
        .o_result    (parse_result)
    );

    dqnlc_out_stage u_out_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (advance && in_last),
        .i_result   (parse_result),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_busy     (out_busy),
        .o_result   (out_result)
    );

    // Pack result item, first field lowest
    assign o_m_tdata = {{(OUT_TDATA_W-RES_W){1'b0}}, out_result.first_name_length,
                        out_result.question_count, out_result.malformed, out_result.match};

    // An end byte facing a full output stays in the input register
    `DQNLC_ASSERT_NEXT(a_end_byte_held, i_clk, i_rst_n,
        in_valid && in_last && o_m_tvalid && !i_m_tready,
        in_valid && in_last)
    // A match always carries a length above the threshold
    `DQNLC_ASSERT_NOW(a_match_len, i_clk, i_rst_n,
        o_m_tvalid && out_result.match,
        out_result.first_name_length > r_length_threshold)
    // No questions means nothing can match or run past the end
    `DQNLC_ASSERT_NOW(a_zero_questions, i_clk, i_rst_n,
        o_m_tvalid && (out_result.question_count == '0),
        !out_result.match && !out_result.malformed && (out_result.first_name_length == '0))
    // A result is loaded only from a held end byte
    `DQNLC_ASSERT_NEXT(a_result_source, i_clk, i_rst_n,
        !o_m_tvalid || i_m_tready,
        o_m_tvalid == $past(advance && in_last))
endmodule

FILE: bench/testbench.sv
// Self-checking bench for dns_question_name_length_check_core: streams DNS payload bytes,
// predicts one verdict per packet in a local parser model and checks the result stream.
// Depends on dqnlc_pkg and the core; the length threshold is programmed over APB.
module testbench;
    import dqnlc_pkg::*;

    // Parser walk states of the local model
    typedef enum logic [2:0] {
        WALK_HEADER,
        WALK_LABEL_LEN,
        WALK_LABEL_BODY,
        WALK_TYPE_CLASS,
        WALK_DONE
    } t_walk;

    // One directed stimulus row; verdict is used only when typed is set
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
        logic              udp;
        bit                typed;
        t_result           verdict;
    } t_row;

    localparam logic [APB_ADDR_W-1:0] THRESHOLD_ADDR = {REG_LENGTH_THRESHOLD, 2'b00};
    localparam int unsigned IDLE_PCT = 28;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_s_tvalid;
    logic                   o_s_tready;
    logic [BYTE_W-1:0]      i_s_tdata;   // [7:0] payload_byte
    logic                   i_s_tlast;   // end_of_packet
    logic                   i_s_tuser;   // udp_with_data
    logic                   o_m_tvalid;
    logic                   i_m_tready;
    // [0] match, [1] malformed, [17:2] question_count, [25:18] first_name_length
    logic [OUT_TDATA_W-1:0] o_m_tdata;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [APB_ADDR_W-1:0]  paddr;
    logic [APB_DATA_W-1:0]  pwdata;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;

    // Local parser state and register shadow
    t_walk             walk;
    logic [3:0]        hdr_idx;
    logic [COUNT_W-1:0] qd_count;
    logic [COUNT_W-1:0] questions_left;
    logic [7:0]        label_left;
    logic [7:0]        name_len;
    logic [7:0]        first_len;
    logic              first_done;
    logic [2:0]        tail_left;
    logic [7:0]        length_limit;

    t_result     expected_verdicts[$];
    logic [7:0]  pkt_bytes[$];
    int          error_count = 0;
    int          packets_closed = 0;
    bit          steady = 1'b0;

    dns_question_name_length_check_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Return the parse state to its idle values
    task automatic clear_parse_state();
        walk           = WALK_HEADER;
        hdr_idx        = '0;
        qd_count       = '0;
        questions_left = '0;
        label_left     = '0;
        name_len       = '0;
        first_len      = '0;
        first_done     = 1'b0;
        tail_left      = '0;
    endtask

    // Start the next question, or finish once none are left
    task automatic open_question();
        if (questions_left == 0) begin
            walk = WALK_DONE;
        end else begin
            walk     = WALK_LABEL_LEN;
            name_len = '0;
        end
    endtask

    // Advance the DNS walk by one payload byte; give a verdict on the last byte
    task automatic parse_dns_byte(input logic [7:0] b, input logic last, input logic udp,
                                  output bit has_verdict, output t_result verdict);
        int   sum;
        logic header_done;
        logic broken;
        has_verdict = 1'b0;
        verdict     = '0;
        case (walk)
            WALK_HEADER: begin
                if (hdr_idx == QDCOUNT_HI_POS)
                    qd_count[15:8] = b;
                else if (hdr_idx == QDCOUNT_LO_POS)
                    qd_count[7:0] = b;
                if (hdr_idx >= HEADER_BYTES_DEF - 1) begin
                    questions_left = qd_count;
                    open_question();
                end else begin
                    hdr_idx = hdr_idx + 4'd1;
                end
            end
            WALK_LABEL_LEN: begin
                if (b != 0) begin
                    // saturate the dotted length at 255
                    sum        = int'(name_len) + int'(b) + 1;
                    name_len   = (sum > 255) ? 8'hFF : 8'(sum);
                    label_left = b;
                    walk       = WALK_LABEL_BODY;
                end else begin
                    tail_left = 3'(TAIL_BYTES);
                    walk      = WALK_TYPE_CLASS;
                end
            end
            WALK_LABEL_BODY: begin
                label_left = label_left - 8'd1;
                if (label_left == 0)
                    walk = WALK_LABEL_LEN;
            end
            WALK_TYPE_CLASS: begin
                tail_left = tail_left - 3'd1;
                if (tail_left == 0) begin
                    if (!first_done) begin
                        first_len  = name_len;
                        first_done = 1'b1;
                    end
                    questions_left = questions_left - 16'd1;
                    open_question();
                end
            end
            default: ;
        endcase
        if (last) begin
            has_verdict = 1'b1;
            header_done = (walk != WALK_HEADER);
            broken = (walk == WALK_LABEL_LEN) || (walk == WALK_LABEL_BODY) ||
                     (walk == WALK_TYPE_CLASS);
            if (udp && header_done) begin
                verdict.match             = first_done && (first_len > length_limit);
                verdict.malformed         = broken;
                verdict.question_count    = qd_count;
                verdict.first_name_length = first_done ? first_len : 8'h00;
            end
            clear_parse_state();
        end
    endtask

    // Offer one payload item, wait for it to be taken, then predict
    task automatic push_byte(input logic [7:0] b, input logic last, input logic udp,
                             input bit typed, input t_result typed_v);
        bit      has_v;
        t_result v;
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        i_s_tlast  <= last;
        i_s_tuser  <= udp;
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
        parse_dns_byte(b, last, udp, has_v, v);
        if (has_v) begin
            expected_verdicts.insert(expected_verdicts.size(), typed ? typed_v : v);
            packets_closed++;
        end
    endtask

    // Write the threshold register, then read it back
    task automatic program_threshold(input logic [APB_DATA_W-1:0] word);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= THRESHOLD_ADDR;
        pwdata  <= word;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        length_limit = word[7:0];
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        if (prdata[7:0] !== length_limit) begin
            error_count++;
            if (error_count <= 10)
                $display("threshold readback: expected %0d, got %0d", length_limit, prdata[7:0]);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Result side: stall at random unless steady, compare each item with the oldest prediction
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_verdicts.size() == 0) begin
                error_count++;
                if (error_count <= 10)
                    $display("verdict with none pending: %h", o_m_tdata);
            end else begin
                want = expected_verdicts.pop_front();
                if (o_m_tdata[0] !== want.match || o_m_tdata[1] !== want.malformed ||
                    o_m_tdata[17:2] !== want.question_count ||
                    o_m_tdata[25:18] !== want.first_name_length ||
                    o_m_tdata[31:26] !== 6'd0) begin
                    error_count++;
                    if (error_count <= 10)
                        $display("verdict mismatch: expected m=%0d bad=%0d qd=%h len=%0d, %s %h",
                                 want.match, want.malformed, want.question_count,
                                 want.first_name_length, "got tdata", o_m_tdata);
                end
            end
        end
        i_m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    // Stimulus: directed rows, then phases of random packets per threshold setting
    initial begin
        t_row       rows[$];
        t_result    v_zero;
        t_result    v_cut;
        logic [APB_DATA_W-1:0] word;
        int         phase_idx;
        int         phase_bytes;
        int         shape;
        int         pick;
        int         qd;
        int         nq;
        int         nlab;
        int         len;
        int         cut;
        int         k;
        logic       udp_final;

        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        i_s_tlast  <= 1'b0;
        i_s_tuser  <= 1'b0;
        i_m_tready <= 1'b0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        clear_parse_state();
        length_limit = 8'h00;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Runt packet, full header with every question missing, and zero questions
        v_zero = '0;
        v_cut  = '0;
        v_cut.malformed      = 1'b1;
        v_cut.question_count = 16'hFFFF;
        rows.insert(rows.size(),
                    '{data: 8'hFF, last: 1'b1, udp: 1'b1, typed: 1'b1, verdict: v_zero});
        for (k = 0; k < HEADER_BYTES_DEF; k++)
            rows.insert(rows.size(),
                        '{data: (k == QDCOUNT_HI_POS || k == QDCOUNT_LO_POS || k[0]) ?
                                8'hFF : 8'h00,
                          last: (k == HEADER_BYTES_DEF - 1), udp: 1'b1,
                          typed: 1'b1, verdict: v_cut});
        for (k = 0; k < HEADER_BYTES_DEF; k++)
            rows.insert(rows.size(),
                        '{data: (k == QDCOUNT_HI_POS || k == QDCOUNT_LO_POS) ?
                                8'h00 : 8'hFF,
                          last: (k == HEADER_BYTES_DEF - 1), udp: 1'b1,
                          typed: 1'b1, verdict: v_zero});
        foreach (rows[r])
            push_byte(rows[r].data, rows[r].last, rows[r].udp, rows[r].typed, rows[r].verdict);
        i_s_tvalid <= 1'b0;

        for (phase_idx = 1; phase_idx <= 5; phase_idx++) begin
            // Hold the sender until every verdict is back
            while (expected_verdicts.size() != 0)
                @(posedge i_clk);
            repeat (8) @(posedge i_clk);
            if (phase_idx == 5)
                break;

            word = $urandom();
            case (phase_idx)
                1: word[7:0] = 8'hFF;
                2: word[7:0] = 8'($urandom_range(1, 254));
                3: word[7:0] = 8'($urandom_range(2, 12));
                default: word[7:0] = 8'h00;
            endcase
            program_threshold(word);
            steady = (phase_idx == 2);

            phase_bytes = 0;
            while (phase_bytes < 200 || (phase_idx == 4 && packets_closed < 48)) begin
                pkt_bytes.delete();
                shape = $urandom_range(99);
                if (shape < 10) begin
                    // runt that ends inside the header
                    len = $urandom_range(1, HEADER_BYTES_DEF - 1);
                    repeat (len) pkt_bytes.insert(pkt_bytes.size(), 8'($urandom()));
                end else if (shape < 18) begin
                    // noise at least as long as the header
                    len = $urandom_range(HEADER_BYTES_DEF, 40);
                    repeat (len) pkt_bytes.insert(pkt_bytes.size(), 8'($urandom()));
                end else begin
                    pick = $urandom_range(99);
                    if (pick < 8)
                        qd = 0;
                    else if (pick < 82)
                        qd = $urandom_range(1, 3);
                    else if (pick < 92)
                        qd = $urandom_range(4, 6);
                    else
                        qd = $urandom_range(0, 65535);
                    for (k = 0; k < HEADER_BYTES_DEF; k++) begin
                        if (k == QDCOUNT_HI_POS)
                            pkt_bytes.insert(pkt_bytes.size(), 8'(qd >> 8));
                        else if (k == QDCOUNT_LO_POS)
                            pkt_bytes.insert(pkt_bytes.size(), 8'(qd));
                        else
                            pkt_bytes.insert(pkt_bytes.size(), 8'($urandom()));
                    end
                    // build fewer questions than counted for large counts
                    nq = (qd <= 3) ? qd : $urandom_range(0, 3);
                    repeat (nq) begin
                        nlab = $urandom_range(0, 4);
                        repeat (nlab) begin
                            len = ($urandom_range(39) == 0) ? $urandom_range(240, 255) :
                                                              $urandom_range(1, 12);
                            pkt_bytes.insert(pkt_bytes.size(), 8'(len));
                            repeat (len) pkt_bytes.insert(pkt_bytes.size(), 8'($urandom()));
                        end
                        pkt_bytes.insert(pkt_bytes.size(), 8'h00);
                        repeat (TAIL_BYTES) pkt_bytes.insert(pkt_bytes.size(), 8'($urandom()));
                    end
                    if ($urandom_range(99) < 20)
                        repeat ($urandom_range(1, 6))
                            pkt_bytes.insert(pkt_bytes.size(), 8'($urandom()));
                    // truncate some packets anywhere
                    if ($urandom_range(99) < 15) begin
                        cut = $urandom_range(1, pkt_bytes.size());
                        while (pkt_bytes.size() > cut)
                            void'(pkt_bytes.pop_back());
                    end
                end
                udp_final = ($urandom_range(99) < 85);
                foreach (pkt_bytes[b])
                    push_byte(pkt_bytes[b], b == pkt_bytes.size() - 1,
                              (b == pkt_bytes.size() - 1) ? udp_final : 1'($urandom()),
                              1'b0, v_zero);
                phase_bytes += pkt_bytes.size();
            end
            i_s_tvalid <= 1'b0;
        end

        if (error_count == 0)
            $display("[dns_question_name_length_check_core] OK");
        else
            $display("[dns_question_name_length_check_core] ERROR");
        $finish;
    end

    // Watchdog
    initial begin
        #4000000;
        $display("[dns_question_name_length_check_core] ERROR");
        $finish;
    end

endmodule

FILE: dns_question_name_length_check_core.f
+incdir+sv
sv/dqnlc_pkg.sv
sv/dqnlc_in_stage.sv
sv/dqnlc_parser.sv
sv/dqnlc_out_stage.sv
sv/dns_question_name_length_check_core.sv
bench/testbench.sv
